// File: hdl/four_pole_ladder_lowpass_core_defines.svh
// Assertion macros for the ladder low-pass core checker.
// Depends on nothing; included by the checker file.
`ifndef FOUR_POLE_LADDER_LOWPASS_CORE_DEFINES_SVH
`define FOUR_POLE_LADDER_LOWPASS_CORE_DEFINES_SVH

// check that c holds in the cycle after a, outside reset
`define LLP_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// same check, also while reset is asserted
`define LLP_ASSERT_NEXT_RST(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

// File: hdl/llp_pkg.sv
// Shared types, constants and rounding helpers for the ladder low-pass core.
// Depends on nothing; used by llp_front, llp_back and the top level.
package llp_pkg;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] C_MIN_Q16  = 17'd328;
  localparam logic [17:0] C_SPAN2    = 18'd130416;
  localparam logic [17:0] RATE_RESET = 18'd48000;
  localparam logic signed [19:0] K_TUNE = 20'sd76022;
  localparam logic signed [19:0] K_FB   = 20'sd9830;
  localparam logic signed [19:0] K_GAIN = 20'sd22946;
  localparam logic signed [19:0] K_ZERO = 20'sd19661;
  localparam logic [4:0] OP_LAST = 5'd16;

  typedef struct packed {
    logic               bad;
    logic [2:0]         ch;
    logic signed [23:0] smp;
    logic [16:0]        c;
    logic [16:0]        res;
  } front_item_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIN, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ACC, B_OUT} back_state_t;

  function automatic logic signed [39:0] rnd16(input logic signed [55:0] p);
    logic signed [55:0] t;
    t = (p + 56'sd32768) >>> 16;
    return t[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: hdl/llp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module llp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/llp_fifo.sv
// Small word queue with push/full and pop/empty sides.
// Depends on nothing.
module llp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule

// File: hdl/llp_front.sv
// Front end: accepts words, holds the rate register, maps cutoff to c by serial division.
// Depends on llp_pkg.
module llp_front #(
  parameter int CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_channel,
  input  logic signed [23:0]   in_sample,
  input  logic [16:0]          in_cutoff_hz,
  input  logic [16:0]          in_resonance,
  input  logic                 cfg_valid,
  input  logic [17:0]          cfg_sample_rate_hz,
  output logic                 mid_push,
  input  logic                 mid_full,
  output llp_pkg::front_item_t mid_item
);
  import llp_pkg::*;

  front_state_t state_r, state_nxt;
  logic [17:0] rate_r, div_r, rem_r;
  logic [15:0] quo_r;
  logic [3:0]  cnt_r;
  front_item_t item_r;
  logic        accept, big;
  logic [33:0] num;
  logic [18:0] trial;
  logic        ge;

  assign in_full  = (state_r != F_IDLE);
  assign accept   = in_push && !in_full;
  assign num      = 34'(in_cutoff_hz) * 34'(C_SPAN2);
  assign big      = (rate_r == '0) || ({in_cutoff_hz, 1'b0} >= rate_r);
  assign trial    = {rem_r, quo_r[15]};
  assign ge       = (trial >= {1'b0, div_r});
  assign mid_item = item_r;

  always_comb begin
    state_nxt = state_r;
    mid_push  = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = (big || (32'(in_channel) >= CHANNELS)) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (cnt_r == 4'd15) begin
          state_nxt = F_FIN;
        end
      end
      F_FIN: state_nxt = F_PUSH;
      F_PUSH: begin
        mid_push = 1'b1;
        if (!mid_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      rate_r  <= RATE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        rate_r <= cfg_sample_rate_hz;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          item_r.bad <= (32'(in_channel) >= CHANNELS);
          item_r.ch  <= in_channel;
          item_r.smp <= in_sample;
          item_r.res <= (in_resonance > ONE_Q16) ? ONE_Q16 : in_resonance;
          item_r.c   <= ONE_Q16;
          rem_r      <= num[33:16];
          quo_r      <= num[15:0];
          div_r      <= rate_r;
          cnt_r      <= '0;
        end
      end
      F_DIV: begin
        rem_r <= ge ? 18'(trial - {1'b0, div_r}) : trial[17:0];
        quo_r <= {quo_r[14:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      F_FIN: item_r.c <= C_MIN_Q16 + {1'b0, quo_r};
      default: ;
    endcase
  end
endmodule

// File: hdl/llp_back.sv
// Back end: coefficient and ladder sequencer on one shared multiplier, state RAMs, result queue.
// Depends on llp_pkg, llp_ram and llp_fifo.
module llp_back #(
  parameter int CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  llp_pkg::front_item_t mid_item,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic signed [23:0]   out_filtered_sample
);
  import llp_pkg::*;

  localparam int ROWS = 4 * CHANNELS;
  localparam int RW   = $clog2(ROWS);

  back_state_t state_r, state_nxt;
  logic [4:0]  op_r, rd_op;
  front_item_t it_r;
  logic        v_r;
  logic [CHANNELS-1:0] chv_r;
  logic [16:0] f_r, f2_r, f4_r, onem_r;
  logic [18:0] fb_r;
  logic [15:0] g_r;
  logic signed [35:0] x_r, acc_r, mul_a;
  logic signed [19:0] mul_b, omf;
  logic signed [55:0] prod_r;
  logic signed [39:0] rp, y;
  logic signed [31:0] ysat, po_rd, pi_rd, po_q, pi_q;
  logic signed [32:0] orow;
  logic signed [23:0] out_r;
  logic [1:0]  rd_pole, wr_pole;
  logic [RW-1:0] raddr, waddr;
  logic        we, ofull, opush;

  assign omf   = 20'sd65536 - $signed({3'b0, f_r});
  assign rp    = rnd16(prod_r);
  assign y     = 40'(acc_r) + rp;
  assign ysat  = sat32(y);
  assign po_rd = v_r ? po_q : '0;
  assign pi_rd = v_r ? pi_q : '0;
  assign orow  = (33'(ysat) + 33'sd16) >>> 5;

  assign rd_op   = (state_r == B_ACC) ? op_r + 1'b1 : op_r;
  assign rd_pole = (rd_op == 5'd7) ? 2'd3 : 2'((rd_op - 5'd9) >> 1);
  assign wr_pole = 2'((op_r - 5'd10) >> 1);
  assign raddr   = RW'(32'(it_r.ch) * 4 + 32'(rd_pole));
  assign waddr   = RW'(32'(it_r.ch) * 4 + 32'(wr_pole));
  assign we      = (state_r == B_ACC) && (op_r >= 5'd10) && !op_r[0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      5'd0: begin mul_a = 36'(it_r.c); mul_b = K_TUNE; end
      5'd1: begin mul_a = 36'(f_r);  mul_b = $signed({3'b0, f_r}); end
      5'd2: begin mul_a = 36'(f2_r); mul_b = $signed({3'b0, f_r}); end
      5'd3: begin mul_a = 36'(f4_r); mul_b = $signed({3'b0, f_r}); end
      5'd4: begin mul_a = 36'(K_FB); mul_b = $signed({3'b0, f2_r}); end
      5'd5: begin mul_a = 36'({it_r.res, 2'b00}); mul_b = $signed({3'b0, onem_r}); end
      5'd6: begin mul_a = 36'(K_GAIN); mul_b = $signed({3'b0, f4_r}); end
      5'd7: begin mul_a = 36'(po_rd); mul_b = $signed({1'b0, fb_r}); end
      5'd8: begin mul_a = x_r; mul_b = $signed({4'b0, g_r}); end
      default: begin
        if (op_r[0]) begin
          mul_a = 36'(pi_rd);
          mul_b = K_ZERO;
        end else begin
          mul_a = 36'(po_rd);
          mul_b = omf;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mid_pop   = 1'b0;
    opush     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!mid_empty && !ofull) begin
          mid_pop   = 1'b1;
          state_nxt = mid_item.bad ? B_OUT : B_MUL;
        end
      end
      B_MUL: state_nxt = B_ACC;
      B_ACC: state_nxt = (op_r == OP_LAST) ? B_OUT : B_MUL;
      B_OUT: begin
        opush     = 1'b1;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      chv_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_ACC) && (op_r == OP_LAST)) begin
        chv_r[it_r.ch] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        it_r  <= mid_item;
        v_r   <= chv_r[mid_item.ch];
        op_r  <= '0;
        out_r <= '0;
      end
      B_MUL: prod_r <= mul_a * mul_b;
      B_ACC: begin
        op_r <= op_r + 1'b1;
        case (op_r)
          5'd0: f_r    <= rp[16:0];
          5'd1: f2_r   <= rp[16:0];
          5'd2: f4_r   <= rp[16:0];
          5'd3: f4_r   <= rp[16:0];
          5'd4: onem_r <= ONE_Q16 - rp[16:0];
          5'd5: fb_r   <= rp[18:0];
          5'd6: g_r    <= rp[15:0];
          5'd7: x_r    <= {{7{it_r.smp[23]}}, it_r.smp, 5'b0} - 36'(rp);
          5'd8: x_r    <= 36'(sat32(rp));
          default: begin
            if (op_r[0]) begin
              acc_r <= x_r + 36'(rp);
            end else begin
              x_r <= 36'(ysat);
              if (op_r == OP_LAST) begin
                if (orow > 33'sd8388607) out_r <= 24'sh7fffff;
                else if (orow < -33'sd8388608) out_r <= 24'sh800000;
                else out_r <= orow[23:0];
              end
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  llp_ram #(.WIDTH(32), .DEPTH(ROWS)) u_po_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ysat),
    .raddr(raddr), .rdata(po_q)
  );

  llp_ram #(.WIDTH(32), .DEPTH(ROWS)) u_pi_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(x_r[31:0]),
    .raddr(raddr), .rdata(pi_q)
  );

  llp_fifo #(.W(24), .DEPTH(2)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(opush), .wdata(out_r), .full(ofull),
    .pop(out_pop), .empty(out_empty), .rdata(out_filtered_sample)
  );
endmodule

// File: hdl/four_pole_ladder_lowpass_core.sv
// Four-pole ladder low-pass core. A word passes the front end (16-step cutoff division,
// skipped when the cutoff clamps or the channel is invalid), the mid queue and the back end.
// The back end's shared multiplier forms 17 products for each valid word, each product in
// a multiply and an accumulate state, between a pop and a push; a new word waits for the push.
// Reset is synchronous, active low: queues empty, rate 48000, every channel's
// filter state reads as zero through per-channel valid bits; no clearing pass.
module four_pole_ladder_lowpass_core #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample,
  input  logic [16:0]        in_cutoff_hz,
  input  logic [16:0]        in_resonance,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [23:0] out_filtered_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [17:0]        cfg_sample_rate_hz
);
  import llp_pkg::*;

  localparam int IW = $bits(front_item_t);

  logic        f_push, f_full, b_pop, b_empty;
  front_item_t f_item, b_item;

  assign cfg_ready = 1'b1;

  llp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_channel(in_channel),
    .in_sample(in_sample), .in_cutoff_hz(in_cutoff_hz), .in_resonance(in_resonance),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_sample_rate_hz(cfg_sample_rate_hz),
    .mid_push(f_push), .mid_full(f_full), .mid_item(f_item)
  );

  llp_fifo #(.W(IW), .DEPTH(2)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(f_push), .wdata(f_item), .full(f_full),
    .pop(b_pop), .empty(b_empty), .rdata(b_item)
  );

  llp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .mid_empty(b_empty), .mid_pop(b_pop), .mid_item(b_item),
    .out_pop(out_pop), .out_empty(out_empty), .out_filtered_sample(out_filtered_sample)
  );
endmodule

// File: hdl/llp_checker.sv
// Port-level checker for the ladder low-pass core, bound to the top level.
// Depends on four_pole_ladder_lowpass_core_defines.svh.
`include "four_pole_ladder_lowpass_core_defines.svh"

module llp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic cfg_ready
);
  `LLP_ASSERT_NEXT_RST(a_reset_idle, !rst_n, out_empty && !in_full && cfg_ready, "not idle after reset")
  `LLP_ASSERT_NEXT(a_busy_after_accept, in_push && !in_full, in_full, "accepted without going busy")
  `LLP_ASSERT_NEXT(a_result_kept, !out_empty && !out_pop, !out_empty, "result dropped without pop")
  `LLP_ASSERT_NEXT(a_cfg_ready, 1'b1, cfg_ready, "cfg port stalled")
endmodule

bind four_pole_ladder_lowpass_core llp_checker u_llp_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .cfg_ready(cfg_ready)
);

// File: tb/tb_checker.sv
// Checker for the ladder low-pass core: watches the input, result and rate channels,
// runs its own fixed-point model of the filter, and compares every result word.
// Depends on nothing but the port widths of four_pole_ladder_lowpass_core.
module tb_checker #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample,
  input  logic [16:0]        in_cutoff_hz,
  input  logic [16:0]        in_resonance,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [23:0] out_filtered_sample,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [17:0]        cfg_sample_rate_hz,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q16 = 65536;
  localparam longint C_MIN = 328;
  localparam longint C_SPAN = 65208;
  localparam longint K_TUNE = 76022;
  localparam longint K_FB = 9830;
  localparam longint K_GAIN = 22946;
  localparam longint K_ZERO = 19661;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic signed [31:0] pole_out[4*CHANNELS];
  logic signed [31:0] pole_in[4*CHANNELS];
  logic [17:0]        rate_hz;
  logic signed [23:0] filtered_q[$];

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint rnd5(longint v);
    return (v + 16) >>> 5;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint umul(longint a, longint b);
    return (a * b + 32768) >> 16;
  endfunction

  function automatic logic signed [23:0] filter_step(logic [2:0] ch, logic signed [23:0] smp,
                                                     logic [16:0] hz, logic [16:0] res);
    longint c, f, f2, f4, fb, g, omf, r, x, y;
    int base;
    if (ch >= CHANNELS) return '0;
    base = ch * 4;
    if (rate_hz == 0 || 2 * longint'(hz) >= longint'(rate_hz)) c = ONE_Q16;
    else c = C_MIN + (C_SPAN * 2 * longint'(hz)) / longint'(rate_hz);
    r = res > ONE_Q16 ? ONE_Q16 : longint'(res);
    f = umul(c, K_TUNE);
    f2 = umul(f, f);
    f4 = umul(umul(f2, f), f);
    fb = umul(r * 4, ONE_Q16 - umul(K_FB, f2));
    g = umul(K_GAIN, f4);
    omf = ONE_Q16 - f;
    x = longint'(smp) * 32;
    x -= rnd16(longint'(pole_out[base+3]) * fb);
    x = sat(rnd16(x * g), S32_MIN, S32_MAX);
    for (int k = 0; k < 4; k++) begin
      y = x + rnd16(longint'(pole_in[base+k]) * K_ZERO)
            + rnd16(longint'(pole_out[base+k]) * omf);
      pole_in[base+k] = 32'(x);
      pole_out[base+k] = 32'(sat(y, S32_MIN, S32_MAX));
      x = pole_out[base+k];
    end
    return 24'(sat(rnd5(longint'(pole_out[base+3])), -8388608, 8388607));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pole_out[i]) begin
        pole_out[i] = '0;
        pole_in[i] = '0;
      end
      rate_hz = 18'd48000;
      filtered_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) rate_hz = cfg_sample_rate_hz;
      if (out_pop && !out_empty) begin
        if (filtered_q.size() == 0) begin
          $error("filtered_sample: unexpected word %0d", out_filtered_sample);
          fail_count <= fail_count + 1;
        end else if (filtered_q[0] !== out_filtered_sample) begin
          $error("filtered_sample: expected %0d actual %0d", filtered_q[0],
                 out_filtered_sample);
          fail_count <= fail_count + 1;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      if (in_push && !in_full)
        filtered_q.push_back(filter_step(in_channel, in_sample, in_cutoff_hz, in_resonance));
      pending <= filtered_q.size();
    end
  end
endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the ladder low-pass core: resets it, steps the rate register
// through several values, offers directed and random words with gaps and stalls.
// Depends on four_pole_ladder_lowpass_core and tb_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [2:0]         in_channel = '0;
  logic signed [23:0] in_sample = '0;
  logic [16:0]        in_cutoff_hz = '0;
  logic [16:0]        in_resonance = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [23:0] out_filtered_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [17:0]        cfg_sample_rate_hz = '0;
  int                 fail_count;
  int                 pending;
  int                 hold_pop = 0;
  logic               stall_req = 1'b0;
  logic               stall_req_q = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  four_pole_ladder_lowpass_core u_top (.*);
  tb_checker u_chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    stall_req_q <= stall_req;
    if (stall_req && !stall_req_q) begin
      hold_pop <= 400;
      out_pop <= 1'b0;
    end else if (hold_pop > 0) begin
      hold_pop <= hold_pop - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic push_word(logic [2:0] ch, logic signed [23:0] smp, logic [16:0] hz,
                           logic [16:0] res, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    in_channel <= ch;
    in_sample <= smp;
    in_cutoff_hz <= hz;
    in_resonance <= res;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_rate(logic [17:0] hz);
    drain();
    cfg_valid <= 1'b1;
    cfg_sample_rate_hz <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_words(int n);
    logic [16:0] hz;
    logic [16:0] res;
    for (int i = 0; i < n; i++) begin
      hz = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 30000));
      res = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      push_word(3'($urandom), 24'($urandom), hz, res, 1'b0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_word(3'd0, 24'sh7fffff, 17'd0, 17'd0, 1'b0);
    push_word(3'd0, 24'sh800000, 17'd96000, 17'd65536, 1'b0);
    push_word(3'd1, 24'sh7fffff, 17'd24000, 17'd65536, 1'b0);
    push_word(3'd1, 24'sh7fffff, 17'd23999, 17'h1ffff, 1'b0);
    push_word(3'd7, 24'sh800000, 17'h1ffff, 17'h10001, 1'b0);
    push_word(3'd7, 24'sh000000, 17'd1, 17'd1, 1'b0);
    push_word(3'd2, 24'sh555555, 17'd12345, 17'd40000, 1'b0);
    push_word(3'd2, 24'shaaaaaa, 17'd100, 17'd65535, 1'b0);
    for (int i = 0; i < 8; i++) push_word(3'd3, 24'sh7fffff, 17'd20000, 17'd65536, 1'b0);
    set_rate(18'd0);
    push_word(3'd4, 24'sh123456, 17'd0, 17'd30000, 1'b0);
    push_word(3'd4, 24'sh800000, 17'd5, 17'd65536, 1'b0);
    set_rate(18'h3ffff);
    push_word(3'd5, 24'sh7fffff, 17'h1ffff, 17'd65536, 1'b0);
    push_word(3'd5, 24'sh7fffff, 17'd1000, 17'd65536, 1'b0);
    set_rate(18'd8000);
    random_words(300);
    set_rate(18'd192000);
    random_words(300);
    stall_req <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      push_word(3'($urandom), 24'($urandom), 17'd5000, 17'd50000, 1'b1);
    end
    set_rate(18'($urandom));
    random_words(300);
    set_rate(18'd48000);
    random_words(300);
    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
